FILE: rtl/uledpwm_pkg.sv
// shared types, constants and decode functions of the uart led pwm frame decoder
// no dependencies; imported by every module of the block
package uledpwm_pkg;

  localparam int NUM_C  = 12;
  localparam int NUM_D  = 8;
  localparam int NUM_CH = NUM_C + NUM_D;
  localparam int CH_W   = $clog2(NUM_CH);

  localparam logic [9:0]  ACC_MAX     = 10'd1023;
  localparam logic [13:0] DUTY_SCALE  = 14'd10000;
  localparam logic [10:0] DUTY_DIV    = 11'd1023;
  localparam int          PROD_W      = 24;

  localparam logic [7:0] REG_COARSE = 8'h30;
  localparam logic [7:0] REG_FINE   = 8'h3C;

  localparam logic [7:0] C_DEV_RESET = 8'h20;
  localparam logic [7:0] D_DEV_RESET = 8'h61;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_C_DEV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_D_DEV = 2'd1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // write commands
  localparam logic [7:0] CMD_W1  = 8'h87;
  localparam logic [7:0] CMD_W2  = 8'h99;
  localparam logic [7:0] CMD_W3  = 8'h1E;
  localparam logic [7:0] CMD_W4  = 8'hAA;
  localparam logic [7:0] CMD_W12 = 8'h2D;
  localparam logic [7:0] CMD_W16 = 8'h33;
  localparam logic [7:0] CMD_W32 = 8'hB4;
  // read commands
  localparam logic [7:0] CMD_R0 = 8'h4B;
  localparam logic [7:0] CMD_R1 = 8'hCC;
  localparam logic [7:0] CMD_R2 = 8'hD2;
  localparam logic [7:0] CMD_R3 = 8'h55;
  localparam logic [7:0] CMD_R4 = 8'hE1;
  localparam logic [7:0] CMD_R5 = 8'h66;
  localparam logic [7:0] CMD_R6 = 8'h78;

  localparam logic [5:0] READ_SKIP = 6'd4;
  localparam logic [5:0] CRC_LEN   = 6'd2;

  typedef enum logic [2:0] {
    PH_CMD, PH_DEV, PH_REG, PH_DATA, PH_CRC, PH_SKIP
  } phase_t;

  typedef enum logic {
    BK_IDLE, BK_EMIT
  } bk_state_t;

  // classified byte, front to back
  typedef struct packed {
    logic       data_vld;
    logic       hit_c;
    logic       hit_d;
    logic [7:0] regaddr;
    logic [7:0] data;
    logic       eor;
  } op_t;

  // one channel read out for duty conversion
  typedef struct packed {
    logic            vld;
    logic [CH_W-1:0] ch;
    logic            last;
    logic [9:0]      acc;
  } emit_t;

  function automatic logic [5:0] write_len(input logic [7:0] cmd);
    logic [5:0] n;
    case (cmd)
      CMD_W1:  n = 6'd1;
      CMD_W2:  n = 6'd2;
      CMD_W3:  n = 6'd3;
      CMD_W4:  n = 6'd4;
      CMD_W12: n = 6'd12;
      CMD_W16: n = 6'd16;
      CMD_W32: n = 6'd32;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

  function automatic logic is_read(input logic [7:0] cmd);
    return (cmd == CMD_R0) || (cmd == CMD_R1) || (cmd == CMD_R2) ||
           (cmd == CMD_R3) || (cmd == CMD_R4) || (cmd == CMD_R5) ||
           (cmd == CMD_R6);
  endfunction

endpackage

FILE: rtl/uart_led_pwm_width_frame_decoder.sv
// top level of the uart led pwm width frame decoder
// depends on uledpwm_pkg, uledpwm_front, uledpwm_fifo, uledpwm_back, uledpwm_duty
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    in_rx_byte, in_end_of_record
//  out      source     out_valid / out_stall  out_channel, out_duty, out_last
//  cfg      sink       cfg_we                 cfg_index, cfg_wdata
//
// one byte is taken per cycle while in_stall is low; the front parser resolves each
// byte in that cycle; a record end starts a readout of 20 items, C1..C12 then D1..D8,
// one per cycle unless held, via the duty pipeline (multiply, estimate, correct, output)
// during readout the 4-entry queue keeps taking bytes, then in_stall rises until the
// readout has gone into the duty pipeline
// out_stall freezes the duty pipeline and readout only; reset is synchronous and needs
// no clearing pass, all 20 accumulators are flip-flops
module uart_led_pwm_width_frame_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [uledpwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_wdata,
  // byte input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_rx_byte,
  input  logic                             in_end_of_record,
  // duty results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [4:0]                       out_channel,
  output logic [13:0]                      out_duty,
  output logic                             out_last
);
  import uledpwm_pkg::*;

  // front to queue
  logic  push;
  op_t   push_op;
  logic  q_full;
  // queue to back
  logic  pop;
  op_t   q_op;
  logic  q_empty;
  // back to duty pipeline
  emit_t emit;
  logic  adv;

  // parser and configuration registers
  uledpwm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_rx_byte       (in_rx_byte),
    .in_end_of_record (in_end_of_record),
    .q_full           (q_full),
    .in_stall         (in_stall),
    .push             (push),
    .push_op          (push_op)
  );

  // decouples parsing from accumulation and readout
  uledpwm_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (q_op),
    .empty   (q_empty),
    .full    (q_full)
  );

  // accumulators, record-end sequencer
  uledpwm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_op    (q_op),
    .adv     (adv),
    .pop     (pop),
    .emit    (emit)
  );

  // duty scaling and output register
  uledpwm_duty u_duty (
    .clk         (clk),
    .rst_n       (rst_n),
    .emit        (emit),
    .out_stall   (out_stall),
    .adv         (adv),
    .out_valid   (out_valid),
    .out_channel (out_channel),
    .out_duty    (out_duty),
    .out_last    (out_last)
  );

endmodule

FILE: rtl/uledpwm_front.sv
// front part: configuration registers and byte-level frame parser
// depends on uledpwm_pkg; hands classified items to the queue
module uledpwm_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [uledpwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_wdata,
  input  logic                             in_valid,
  input  logic [7:0]                       in_rx_byte,
  input  logic                             in_end_of_record,
  input  logic                             q_full,
  output logic                             in_stall,
  output logic                             push,
  output uledpwm_pkg::op_t                 push_op
);
  import uledpwm_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [5:0] rem_r, rem_nxt;
  logic [7:0] dev_r, dev_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic       stop_r, stop_nxt;
  logic [7:0] cdev_r, ddev_r;
  logic       accept;
  logic [5:0] wlen;
  logic [5:0] rem_dec;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign wlen     = write_len(in_rx_byte);
  assign rem_dec  = rem_r - 6'd1;

  // next parse state
  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    dev_nxt   = dev_r;
    reg_nxt   = reg_r;
    stop_nxt  = stop_r;
    if (!stop_r) begin
      unique case (phase_r)
        PH_CMD: begin
          if (wlen != 6'd0) begin
            rem_nxt   = wlen;
            phase_nxt = PH_DEV;
          end else if (is_read(in_rx_byte)) begin
            rem_nxt   = READ_SKIP;
            phase_nxt = PH_SKIP;
          end else begin
            stop_nxt = 1'b1;
          end
        end
        PH_DEV: begin
          dev_nxt   = in_rx_byte;
          phase_nxt = PH_REG;
        end
        PH_REG: begin
          reg_nxt   = in_rx_byte;
          phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          reg_nxt = reg_r + 8'd1;
          rem_nxt = rem_dec;
          if (rem_dec == 6'd0) begin
            rem_nxt   = CRC_LEN;
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC, PH_SKIP: begin
          rem_nxt = rem_dec;
          if (rem_dec == 6'd0) phase_nxt = PH_CMD;
        end
        default: begin
          phase_nxt = PH_CMD;
        end
      endcase
    end
    // record end drops any unfinished frame
    if (in_end_of_record) begin
      phase_nxt = PH_CMD;
      rem_nxt   = 6'd0;
      dev_nxt   = 8'd0;
      reg_nxt   = 8'd0;
      stop_nxt  = 1'b0;
    end
  end

  // classified item
  always_comb begin
    push_op.data_vld = !stop_r && (phase_r == PH_DATA);
    push_op.hit_c    = (dev_r == cdev_r);
    push_op.hit_d    = (dev_r == ddev_r);
    push_op.regaddr  = reg_r;
    push_op.data     = in_rx_byte;
    push_op.eor      = in_end_of_record;
    push             = accept && (push_op.data_vld || push_op.eor);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CMD;
      rem_r   <= 6'd0;
      dev_r   <= 8'd0;
      reg_r   <= 8'd0;
      stop_r  <= 1'b0;
      cdev_r  <= C_DEV_RESET;
      ddev_r  <= D_DEV_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_C_DEV: cdev_r <= cfg_wdata;
          CFG_D_DEV: ddev_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        phase_r <= phase_nxt;
        rem_r   <= rem_nxt;
        dev_r   <= dev_nxt;
        reg_r   <= reg_nxt;
        stop_r  <= stop_nxt;
      end
    end
  end

endmodule

FILE: rtl/uledpwm_fifo.sv
// short item queue between front and back
// depends on uledpwm_pkg for the item type and depth
module uledpwm_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  uledpwm_pkg::op_t push_op,
  input  logic             pop,
  output uledpwm_pkg::op_t pop_op,
  output logic             empty,
  output logic             full
);
  import uledpwm_pkg::*;

  op_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] cnt_r;
  logic               do_push, do_pop;

  assign empty   = (cnt_r == FIFO_CW'(0));
  assign full    = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_op  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + FIFO_CW'(1);
        2'b01:   cnt_r <= cnt_r - FIFO_CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: rtl/uledpwm_back.sv
// back part: width accumulators and the record-end readout sequencer
// depends on uledpwm_pkg; feeds uledpwm_duty one channel per advance
module uledpwm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  uledpwm_pkg::op_t   q_op,
  input  logic               adv,
  output logic               pop,
  output uledpwm_pkg::emit_t emit
);
  import uledpwm_pkg::*;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CH - 1);

  bk_state_t       state_r, state_nxt;
  logic [CH_W-1:0] cnt_r;
  logic [9:0]      acc_r [NUM_CH];
  logic [9:0]      acc_nxt [NUM_CH];
  logic            issue, clear;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_empty && q_op.eor) state_nxt = BK_EMIT;
      BK_EMIT: if (adv && cnt_r == LAST_CH) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop   = (state_r == BK_IDLE) && !q_empty;
    issue = (state_r == BK_EMIT);
    clear = issue && adv && (cnt_r == LAST_CH);
  end

  assign emit.vld  = issue;
  assign emit.ch   = cnt_r;
  assign emit.last = (cnt_r == LAST_CH);
  assign emit.acc  = acc_r[cnt_r];

  // per-channel update: coarse register adds byte<<2, fine registers add 2-bit parts
  for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
    localparam int  OFF = (i < NUM_C) ? (NUM_C - 1 - i) : (NUM_CH - 1 - i);
    localparam int  GRP = OFF / 3;
    localparam int  SUB = OFF % 3;
    localparam logic [7:0] COARSE_A = REG_COARSE + 8'(OFF);
    localparam logic [7:0] FINE_A   = REG_FINE + 8'(GRP);
    logic        hit;
    logic [9:0]  amount;
    logic [10:0] sum;

    assign hit = (i < NUM_C) ? q_op.hit_c : q_op.hit_d;

    always_comb begin
      amount = 10'd0;
      if (pop && q_op.data_vld && hit) begin
        if (q_op.regaddr == COARSE_A)    amount = {q_op.data, 2'b00};
        else if (q_op.regaddr == FINE_A) amount = {8'd0, q_op.data[2*SUB +: 2]};
      end
      sum = {1'b0, acc_r[i]} + {1'b0, amount};
      if (clear)                        acc_nxt[i] = 10'd0;
      else if (sum > {1'b0, ACC_MAX})   acc_nxt[i] = ACC_MAX;
      else                              acc_nxt[i] = sum[9:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) acc_r[i] <= 10'd0;
      else        acc_r[i] <= acc_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (clear)             cnt_r <= '0;
      else if (issue && adv) cnt_r <= cnt_r + CH_W'(1);
    end
  end

endmodule

FILE: rtl/uledpwm_duty.sv
// duty conversion pipeline: acc*10000/1023 over four stages, last stage is the output register
// depends on uledpwm_pkg; the whole pipeline holds while the output is stalled
module uledpwm_duty (
  input  logic                          clk,
  input  logic                          rst_n,
  input  uledpwm_pkg::emit_t            emit,
  input  logic                          out_stall,
  output logic                          adv,
  output logic                          out_valid,
  output logic [uledpwm_pkg::CH_W-1:0] out_channel,
  output logic [13:0]                   out_duty,
  output logic                          out_last
);
  import uledpwm_pkg::*;

  logic                s1_vld_r, s2_vld_r, s3_vld_r;
  logic [CH_W-1:0]     s1_ch_r, s2_ch_r, s3_ch_r;
  logic                s1_last_r, s2_last_r, s3_last_r;
  logic [9:0]          s1_acc_r;
  logic [PROD_W-1:0]   s2_x_r, s3_x_r;
  logic [13:0]         s3_q_r;
  logic [PROD_W-1:0]   est;
  logic [PROD_W-1:0]   qmul, rem;
  logic [13:0]         duty_nxt;

  assign adv = !out_valid || !out_stall;

  // x/1023 from below: x*(1 + 2^-10 + 2^-20)/1024 is short by at most one
  assign est = s2_x_r + (s2_x_r >> 10) + (s2_x_r >> 20);

  assign qmul     = (PROD_W'(s3_q_r) << 10) - PROD_W'(s3_q_r);
  assign rem      = s3_x_r - qmul;
  assign duty_nxt = (rem >= PROD_W'(DUTY_DIV)) ? s3_q_r + 14'd1 : s3_q_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ch_r     <= emit.ch;
      s1_last_r   <= emit.last;
      s1_acc_r    <= emit.acc;
      s2_ch_r     <= s1_ch_r;
      s2_last_r   <= s1_last_r;
      s2_x_r      <= PROD_W'(s1_acc_r) * PROD_W'(DUTY_SCALE);
      s3_ch_r     <= s2_ch_r;
      s3_last_r   <= s2_last_r;
      s3_x_r      <= s2_x_r;
      s3_q_r      <= est[23:10];
      out_channel <= s3_ch_r;
      out_last    <= s3_last_r;
      out_duty    <= duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= emit.vld;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      out_valid <= s3_vld_r;
    end
  end

endmodule

FILE: rtl/uledpwm_checker.sv
// port-level checks of the uart led pwm width frame decoder
// depends on uledpwm_pkg; bound to the top level below
module uledpwm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_channel,
  input logic [13:0] out_duty,
  input logic        out_last
);
  import uledpwm_pkg::*;

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_channel) &&
      $stable(out_duty) && $stable(out_last))
    else $error("stalled result item changed");

  // last flag only on the final channel
  a_last_ch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_channel == 5'(NUM_CH - 1))))
    else $error("last flag and channel disagree");

  // readout runs through consecutive channels
  a_ch_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      !out_valid || (out_channel == $past(out_channel) + 5'd1))
    else $error("channel sequence broken");

  // duty never exceeds full scale
  a_duty_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duty <= DUTY_SCALE)
    else $error("duty above full scale");

  // reset empties the output
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind uart_led_pwm_width_frame_decoder uledpwm_checker u_uledpwm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_channel (out_channel),
  .out_duty    (out_duty),
  .out_last    (out_last)
);

FILE: tb/uledpwm_duty_checker.sv
// result checker for the uart led pwm width frame decoder: follows config writes and accepted
// bytes, predicts the 20 duty items of each record and compares them with the output channel
// depends on uledpwm_pkg for command codes, register bases and parse phases
module uledpwm_duty_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [uledpwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                        cfg_wdata,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [7:0]                        in_rx_byte,
  input  logic                              in_end_of_record,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [4:0]                        out_channel,
  input  logic [13:0]                       out_duty,
  input  logic                              out_last,
  output int                                mismatches,
  output int                                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import uledpwm_pkg::*;

  typedef struct packed {
    logic [4:0]  channel;
    logic [13:0] duty;
    logic        last;
  } duty_item_t;

  duty_item_t duty_expected[$];

  logic [7:0] c_dev;
  logic [7:0] d_dev;
  phase_t     phase;
  logic [5:0] remaining;
  logic [7:0] frame_dev;
  logic [7:0] frame_reg;
  logic       halted;
  logic [9:0] width_acc[NUM_CH];
  int         reports;

  function automatic int data_len(input logic [7:0] code);
    case (code)
      CMD_W1:  return 1;
      CMD_W2:  return 2;
      CMD_W3:  return 3;
      CMD_W4:  return 4;
      CMD_W12: return 12;
      CMD_W16: return 16;
      CMD_W32: return 32;
      default: return 0;
    endcase
  endfunction

  function automatic bit skip_code(input logic [7:0] code);
    case (code)
      CMD_R0, CMD_R1, CMD_R2, CMD_R3, CMD_R4, CMD_R5, CMD_R6: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic add_width(input int idx, input int amount);
    int sum;
    sum = int'(width_acc[idx]) + amount;
    if (sum > int'(ACC_MAX)) width_acc[idx] = ACC_MAX;
    else width_acc[idx] = 10'(sum);
  endtask

  // one data byte into a string of n channels starting at base
  task automatic feed_string(input int base, input int n, input int r, input int d);
    int q;
    int off;
    if (r >= int'(REG_COARSE) && r < int'(REG_COARSE) + n) begin
      add_width(base + n - 1 - (r - int'(REG_COARSE)), d << 2);
    end else if (r >= int'(REG_FINE) && r <= int'(REG_FINE) + 3) begin
      q = r - int'(REG_FINE);
      for (int j = 0; j < 3; j++) begin
        off = 3 * q + j;
        if (off < n) add_width(base + n - 1 - off, (d >> (2 * j)) & 3);
      end
    end
  endtask

  task automatic clear_record();
    phase     = PH_CMD;
    remaining = '0;
    frame_dev = '0;
    frame_reg = '0;
    halted    = 1'b0;
    foreach (width_acc[k]) width_acc[k] = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eor);
    int         n;
    duty_item_t item;
    if (!halted) begin
      case (phase)
        PH_CMD: begin
          n = data_len(b);
          if (n != 0) begin
            remaining = 6'(n);
            phase     = PH_DEV;
          end else if (skip_code(b)) begin
            remaining = READ_SKIP;
            phase     = PH_SKIP;
          end else begin
            halted = 1'b1;
          end
        end
        PH_DEV: begin
          frame_dev = b;
          phase     = PH_REG;
        end
        PH_REG: begin
          frame_reg = b;
          phase     = PH_DATA;
        end
        PH_DATA: begin
          if (frame_dev == c_dev) feed_string(0, NUM_C, frame_reg, b);
          if (frame_dev == d_dev) feed_string(NUM_C, NUM_D, frame_reg, b);
          frame_reg = frame_reg + 8'd1;
          remaining = remaining - 6'd1;
          if (remaining == 0) begin
            remaining = CRC_LEN;
            phase     = PH_CRC;
          end
        end
        default: begin
          remaining = remaining - 6'd1;
          if (remaining == 0) phase = PH_CMD;
        end
      endcase
    end
    if (eor) begin
      for (int k = 0; k < NUM_CH; k++) begin
        item.channel = 5'(k);
        item.duty    = 14'(int'(width_acc[k]) * 10000 / 1023);
        item.last    = (k == NUM_CH - 1);
        duty_expected.push_back(item);
      end
      clear_record();
    end
  endtask

  always @(posedge clk) begin : watch
    duty_item_t want;
    int         errs;
    if (!rst_n) begin
      c_dev = C_DEV_RESET;
      d_dev = D_DEV_RESET;
      clear_record();
      duty_expected.delete();
      reports = 0;
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      errs = mismatches;
      // compare before predicting so a fresh expectation never meets this edge's output
      if (out_valid && !out_stall) begin
        if (duty_expected.size() == 0) begin
          errs++;
          if (reports < 10)
            $display("result with nothing pending: ch %0d duty %0d last %0d",
                     out_channel, out_duty, out_last);
          reports++;
        end else begin
          want = duty_expected.pop_front();
          if (out_channel !== want.channel || out_duty !== want.duty ||
              out_last !== want.last) begin
            errs++;
            if (reports < 10)
              $display("duty mismatch: expected ch %0d duty %0d last %0d, got ch %0d duty %0d last %0d",
                       want.channel, want.duty, want.last, out_channel, out_duty, out_last);
            reports++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_C_DEV: c_dev = cfg_wdata;
          CFG_D_DEV: d_dev = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_byte(in_rx_byte, in_end_of_record);
      mismatches  <= errs;
      outstanding <= duty_expected.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// top of the uart led pwm width frame decoder bench: clock, reset, byte records, config phases
// and random back-pressure; depends on uledpwm_pkg, the decoder rtl and uledpwm_duty_checker
// the checker does all prediction and comparison, this module gives the verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import uledpwm_pkg::*;

  // cycles with no item accepted on either channel before the run is declared hung;
  // the longest honest quiet stretch is reset or a settle pause, well under this
  localparam int STALL_LIMIT = 500;
  // items per config phase after the directed records
  localparam int PHASE_ITEMS = 96;
  localparam int NUM_PHASES  = 5;
  // config index with no register behind it, written once to see it is ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_rx_byte = '0;
  logic                 in_end_of_record = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [4:0]           out_channel;
  logic [13:0]          out_duty;
  logic                 out_last;
  int                   mismatches;
  int                   outstanding;

  // command tables in matching order with the data lengths
  logic [7:0] write_codes[7] = '{CMD_W1, CMD_W2, CMD_W3, CMD_W4, CMD_W12, CMD_W16, CMD_W32};
  int         frame_lens[7]  = '{1, 2, 3, 4, 12, 16, 32};
  logic [7:0] read_codes[7]  = '{CMD_R0, CMD_R1, CMD_R2, CMD_R3, CMD_R4, CMD_R5, CMD_R6};

  logic [7:0] record_bytes[$];
  int         items_sent = 0;
  bit         gaps_on = 1'b1;
  // bench copy of the device registers, used only to aim frames at the strings
  logic [7:0] c_dev = C_DEV_RESET;
  logic [7:0] d_dev = D_DEV_RESET;

  always #5 clk = ~clk;

  uart_led_pwm_width_frame_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .in_end_of_record (in_end_of_record),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_channel      (out_channel),
    .out_duty         (out_duty),
    .out_last         (out_last)
  );

  uledpwm_duty_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .in_end_of_record (in_end_of_record),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_channel      (out_channel),
    .out_duty         (out_duty),
    .out_last         (out_last),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // one byte item: optional gap, then hold valid and payload until not stalled
  task automatic push_byte(input logic [7:0] b, input logic eor);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_rx_byte       <= b;
    in_end_of_record <= eor;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // send the built record, marking its last byte as the record end
  task automatic send_record();
    foreach (record_bytes[i]) push_byte(record_bytes[i], i == record_bytes.size() - 1);
    record_bytes.delete();
  endtask

  // stop sending and wait until every predicted duty item has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // new device pair, only once the block is idle; extra cycles cover the duty pipeline
  task automatic configure(input logic [7:0] c, input logic [7:0] d, input bit spare);
    drain();
    repeat (8) @(posedge clk);
    write_reg(CFG_C_DEV, c);
    write_reg(CFG_D_DEV, d);
    if (spare) write_reg(CFG_SPARE, 8'hA5);
    cfg_we <= 1'b0;
    c_dev = c;
    d_dev = d;
  endtask

  // write frame aimed mostly at the pwm registers of either string
  task automatic add_write_frame();
    int         idx;
    int         len;
    logic [7:0] dev;
    logic [7:0] regaddr;
    idx = $urandom_range(0, 6);
    // keep the 32-byte frames rarer so records stay short
    if (idx == 6 && $urandom_range(0, 1) == 1) idx = $urandom_range(0, 3);
    len = frame_lens[idx];
    case ($urandom_range(0, 7))
      0, 1, 2: dev = c_dev;
      3, 4, 5: dev = d_dev;
      6:       dev = 8'($urandom);
      default: dev = c_dev ^ (8'h01 << $urandom_range(0, 7));
    endcase
    case ($urandom_range(0, 5))
      0, 1, 2: regaddr = 8'(REG_COARSE + $urandom_range(0, 15));
      3:       regaddr = 8'(REG_COARSE - $urandom_range(1, len));   // run up into the window
      4:       regaddr = 8'(8'hF0 + $urandom_range(0, 15));         // address wraps past 0xff
      default: regaddr = 8'($urandom);
    endcase
    record_bytes.push_back(write_codes[idx]);
    record_bytes.push_back(dev);
    record_bytes.push_back(regaddr);
    repeat (len) record_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
    repeat (2) record_bytes.push_back(8'($urandom));   // crc, not checked by the block
  endtask

  task automatic add_read_frame();
    record_bytes.push_back(read_codes[$urandom_range(0, 6)]);
    repeat (4) record_bytes.push_back(8'($urandom));
  endtask

  // unknown command (almost always) followed by junk the parser must ignore
  task automatic add_stop();
    record_bytes.push_back(8'($urandom));
    repeat ($urandom_range(0, 4)) record_bytes.push_back(8'($urandom));
  endtask

  task automatic random_record();
    int frames;
    int cut;
    if ($urandom_range(0, 9) == 0) begin
      // pure noise record
      repeat ($urandom_range(1, 10)) record_bytes.push_back(8'($urandom));
    end else begin
      frames = $urandom_range(1, 4);
      repeat (frames) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: add_write_frame();
          7, 8:                add_read_frame();
          default:             add_stop();
        endcase
      end
      // record ending inside a frame
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, record_bytes.size());
        while (record_bytes.size() > cut) void'(record_bytes.pop_back());
      end
    end
    // some records go out back to back, most with random gaps
    gaps_on = ($urandom_range(0, 3) != 0);
    send_record();
    // now and then hold off until every result of the record is out
    if ($urandom_range(0, 5) == 0) drain();
  endtask

  // result side: a random stall before each item, with calm stretches of no stall at all
  initial begin : result_stall
    int hold;
    bit calm;
    calm = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      hold = calm ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // hang detection: too long without any item moving on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] dev;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset devices: coarse 0xff plus fine 0xff saturates C12 at full duty,
    // fine register also feeds C11 and C10 with the low bits
    record_bytes = '{CMD_W1, C_DEV_RESET, REG_COARSE, 8'hFF, 8'h12, 8'h34,
                     CMD_W1, C_DEV_RESET, REG_FINE, 8'hFF, 8'h56, 8'h78};
    send_record();
    // read frame skipped, then a D write that the record end cuts after its first data byte
    record_bytes = '{CMD_R0, 8'h11, 8'h22, 8'h33, 8'h44,
                     CMD_W2, D_DEV_RESET, 8'h37, 8'h01};
    send_record();
    // unknown command stops parsing, the write code after it is ignored
    record_bytes = '{8'h00, CMD_W1};
    send_record();

    // config phases: reset values, both extremes each way, one shared device, random pair
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1: configure(8'h00, 8'hFF, 1'b0);
        2: configure(8'hFF, 8'h00, 1'b0);
        3: begin
          dev = 8'($urandom);
          configure(dev, dev, 1'b0);
        end
        4: configure(8'($urandom), 8'($urandom), 1'b1);
        default: ;
      endcase
      while (items_sent < 23 + (p + 1) * PHASE_ITEMS) random_record();
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: uart_led_pwm_width_frame_decoder.f
rtl/uledpwm_pkg.sv
rtl/uledpwm_front.sv
rtl/uledpwm_fifo.sv
rtl/uledpwm_back.sv
rtl/uledpwm_duty.sv
rtl/uart_led_pwm_width_frame_decoder.sv
rtl/uledpwm_checker.sv
tb/uledpwm_duty_checker.sv
tb/testbench.sv
